### hw/rtl/gfm_pkg.sv
// gfm_pkg: shared types and constants of the gated frequency meter.
// No dependencies; imported by every module of the block.
package gfm_pkg;

    localparam int DATA_W     = 32;
    localparam int FREQ_W     = 40;
    localparam int TIMEOUT_W  = 23;
    localparam int LIMIT_W    = 33;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GATE_TIME       = 1'b0,
        REG_MISSING_TIMEOUT = 1'b1
    } gfm_reg_t;

    localparam logic [DATA_W-1:0]  GATE_TIME_RESET = 32'd1000000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 33'd1000000;
    localparam logic [9:0]         US_PER_MS       = 10'd1000;

    // 1e6 us/s times 256 for the Q8 result
    localparam int                 SCALE_W    = 28;
    localparam logic [SCALE_W-1:0] FREQ_SCALE = 28'd256000000;
    localparam int                 NUM_W      = 59;
    localparam int                 QHI_W      = NUM_W - FREQ_W;
    localparam int                 DIV_STEPS  = FREQ_W;
    localparam int                 STEP_CNT_W = 6;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_ADDR_W = 1;
    localparam int QUEUE_CNT_W  = 2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ZERO   = 2'd1,
        OP_HOLD   = 2'd2,
        OP_DIVIDE = 2'd3
    } gfm_op_t;

    typedef struct packed {
        gfm_op_t           op;
        logic [DATA_W-1:0] raw_count;
        logic [DATA_W-1:0] edge_age_us;
        logic              sig_lost;
        logic [DATA_W-1:0] elapsed;
        logic [DATA_W-1:0] delta;
    } gfm_entry_t;

endpackage

### hw/rtl/gfm_ifs.sv
// gfm_ifs: valid/ready channel interfaces for sample and result words.
// Depends on gfm_pkg for field widths.
interface gfm_in_if import gfm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic signed [DATA_W-1:0] count_value;
    logic        [DATA_W-1:0] time_us;

    modport source (output valid, command, count_value, time_us, input ready);
    modport sink   (input valid, command, count_value, time_us, output ready);
endinterface

interface gfm_out_if import gfm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] raw_count;
    logic [DATA_W-1:0] edge_age_us;
    logic [FREQ_W-1:0] frequency_q8;
    logic              sig_lost;

    modport source (output valid, raw_count, edge_age_us, frequency_q8, sig_lost,
                    input ready);
    modport sink   (input valid, raw_count, edge_age_us, frequency_q8, sig_lost,
                    output ready);
endinterface

### hw/rtl/gfm_front.sv
// gfm_front: accepts sample words, tracks window and edge state, classifies work.
// Depends on gfm_pkg and gfm_ifs; feeds gfm_queue.
module gfm_front import gfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    gfm_in_if.sink               sample,
    output gfm_entry_t           push_entry,
    output logic                 push_valid,
    input  logic                 push_ready
);

    logic [DATA_W-1:0]  gate_reg,  gate_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [DATA_W-1:0]  win_time_reg,  win_time_next;
    logic [DATA_W-1:0]  win_count_reg, win_count_next;
    logic [DATA_W-1:0]  last_edge_reg, last_edge_next;

    logic              accept;
    logic [DATA_W-1:0] count_u;
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] delta;
    logic              positive;
    logic              at_least_two;
    logic              publish;
    logic [DATA_W-1:0] edge_at;
    logic [DATA_W-1:0] age;
    logic              missing;

    assign accept       = sample.valid && push_ready;
    assign sample.ready = push_ready;
    assign push_valid   = sample.valid;

    assign count_u      = DATA_W'(sample.count_value);
    assign elapsed      = sample.time_us - win_time_reg;
    assign delta        = count_u - win_count_reg;
    assign positive     = (delta != '0) && !delta[DATA_W-1];
    assign at_least_two = positive && (delta[DATA_W-1:1] != '0);
    assign publish      = elapsed >= gate_reg;
    assign edge_at      = positive ? sample.time_us : last_edge_reg;
    assign age          = (edge_at == '0) ? '1 : (sample.time_us - edge_at);
    assign missing      = {1'b0, age} > limit_reg;

    always_comb
    begin
        gate_next  = gate_reg;
        limit_next = limit_reg;
        if (cfg_we)
        begin
            case (gfm_reg_t'(cfg_index))
                REG_GATE_TIME:       gate_next  = cfg_data;
                REG_MISSING_TIMEOUT: limit_next = LIMIT_W'(cfg_data[TIMEOUT_W-1:0])
                                                  * LIMIT_W'(US_PER_MS);
                default:             gate_next  = gate_reg;
            endcase
        end
    end

    always_comb
    begin
        win_time_next         = win_time_reg;
        win_count_next        = win_count_reg;
        last_edge_next        = last_edge_reg;
        push_entry.op          = OP_HOLD;
        push_entry.raw_count   = count_u;
        push_entry.edge_age_us = age;
        push_entry.sig_lost    = missing;
        push_entry.elapsed     = elapsed;
        push_entry.delta       = delta;
        if (sample.command)
        begin
            push_entry.op          = OP_CLEAR;
            push_entry.raw_count   = '0;
            push_entry.edge_age_us = '0;
            push_entry.sig_lost    = 1'b0;
            win_time_next          = '0;
            win_count_next         = '0;
            last_edge_next         = '0;
        end
        else if (win_time_reg == '0)
        begin
            push_entry.op          = OP_ZERO;
            push_entry.edge_age_us = '0;
            push_entry.sig_lost    = 1'b0;
            win_time_next          = sample.time_us;
            win_count_next         = count_u;
        end
        else
        begin
            last_edge_next = edge_at;
            if (publish)
            begin
                win_time_next  = sample.time_us;
                win_count_next = count_u;
            end
            if (missing || (publish && !at_least_two))
                push_entry.op = OP_CLEAR;
            else if (publish)
                push_entry.op = OP_DIVIDE;
            else
                push_entry.op = OP_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg      <= GATE_TIME_RESET;
            limit_reg     <= LIMIT_RESET;
            win_time_reg  <= '0;
            win_count_reg <= '0;
            last_edge_reg <= '0;
        end
        else
        begin
            gate_reg  <= gate_next;
            limit_reg <= limit_next;
            if (accept)
            begin
                win_time_reg  <= win_time_next;
                win_count_reg <= win_count_next;
                last_edge_reg <= last_edge_next;
            end
        end
    end

endmodule

### hw/rtl/gfm_queue.sv
// gfm_queue: short FIFO of classified words between front and back.
// Depends on gfm_pkg.
module gfm_queue import gfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  gfm_entry_t push_entry,
    input  logic       push_valid,
    output logic       push_ready,
    output gfm_entry_t pop_entry,
    output logic       pop_valid,
    input  logic       pop_ready
);

    gfm_entry_t              mem [QUEUE_DEPTH];
    logic [QUEUE_ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  fill_reg,   fill_next;
    logic                    do_push;
    logic                    do_pop;

    assign push_ready = fill_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### hw/rtl/gfm_back.sv
// gfm_back: executes queued words; restoring divider for published frequency.
// Depends on gfm_pkg and gfm_ifs; fed by gfm_queue, drives the result channel.
module gfm_back import gfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  gfm_entry_t pop_entry,
    input  logic       pop_valid,
    output logic       pop_ready,
    gfm_out_if.source  result
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_CHK  = 4'b0100,
        ST_DIV  = 4'b1000
    } gfm_state_t;

    gfm_state_t            state_reg, state_next;
    gfm_entry_t            cur_reg,   cur_next;
    logic [NUM_W-1:0]      prod_reg,  prod_next;
    logic [DATA_W-1:0]     rem_reg,   rem_next;
    logic [FREQ_W-1:0]     quot_reg,  quot_next;
    logic [STEP_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [FREQ_W-1:0]     held_reg,  held_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     out_raw_reg,   out_raw_next;
    logic [DATA_W-1:0]     out_age_reg,   out_age_next;
    logic [FREQ_W-1:0]     out_freq_reg,  out_freq_next;
    logic                  out_miss_reg,  out_miss_next;

    logic              out_free;
    logic              pop;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;
    logic              fits;

    assign out_free  = !out_valid_reg || result.ready;
    assign pop_ready = (state_reg == ST_IDLE) && out_free;
    assign pop       = pop_valid && pop_ready;

    assign shifted = {rem_reg, quot_reg[FREQ_W-1]};
    assign trial   = shifted - {1'b0, cur_reg.elapsed};
    assign fits    = shifted >= {1'b0, cur_reg.elapsed};

    assign result.valid        = out_valid_reg;
    assign result.raw_count    = out_raw_reg;
    assign result.edge_age_us  = out_age_reg;
    assign result.frequency_q8 = out_freq_reg;
    assign result.sig_lost     = out_miss_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_raw_next   = out_raw_reg;
        out_age_next   = out_age_reg;
        out_freq_next  = out_freq_reg;
        out_miss_next  = out_miss_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    cur_next = pop_entry;
                    if (pop_entry.op == OP_DIVIDE)
                        state_next = ST_MUL;
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_raw_next   = pop_entry.raw_count;
                        out_age_next   = pop_entry.edge_age_us;
                        out_miss_next  = pop_entry.sig_lost;
                        case (pop_entry.op)
                            OP_CLEAR:
                            begin
                                out_freq_next = '0;
                                held_next     = '0;
                            end
                            OP_ZERO: out_freq_next = '0;
                            OP_HOLD: out_freq_next = held_reg;
                            default: out_freq_next = held_reg;
                        endcase
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = NUM_W'(cur_reg.delta[DATA_W-2:0]) * NUM_W'(FREQ_SCALE);
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (DATA_W'(prod_reg[NUM_W-1:FREQ_W]) >= cur_reg.elapsed)
                begin
                    held_next      = '1;
                    out_valid_next = 1'b1;
                    out_raw_next   = cur_reg.raw_count;
                    out_age_next   = cur_reg.edge_age_us;
                    out_freq_next  = '1;
                    out_miss_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    rem_next   = DATA_W'(prod_reg[NUM_W-1:FREQ_W]);
                    quot_next  = prod_reg[FREQ_W-1:0];
                    cnt_next   = STEP_CNT_W'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
                quot_next = {quot_reg[FREQ_W-2:0], fits};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    held_next      = quot_next;
                    out_valid_next = 1'b1;
                    out_raw_next   = cur_reg.raw_count;
                    out_age_next   = cur_reg.edge_age_us;
                    out_freq_next  = quot_next;
                    out_miss_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        out_raw_reg  <= out_raw_next;
        out_age_reg  <= out_age_next;
        out_freq_reg <= out_freq_next;
        out_miss_reg <= out_miss_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register is free for the whole division
    a_div_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !out_valid_reg)
        else $error("result word pending during division");

    // last divide step always publishes a word
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("division finished without result word");

    // missing signal always reports zero frequency
    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_miss_reg) |-> (out_freq_reg == '0))
        else $error("nonzero frequency with signal missing");

    // held frequency is cleared whenever a missing word is issued
    a_missing_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_entry.sig_lost) |=> (held_reg == '0))
        else $error("held frequency kept after missing signal");

endmodule

### hw/rtl/gated_frequency_meter_unit.sv
// gated_frequency_meter_unit: top level, front classifier, queue and divider back end.
// Path: a publishing word goes through the queue, multiply, range check and a 40-step
// restoring divide; one that saturates ends at the range check; others skip both.
// Throughput: one sample word per cycle into a 2-deep queue unless full; the back
// end takes one non-publishing word per cycle if results drain, none during a divide.
// Reset: rst_n clears the control state; gate time to 1000000 us, timeout to 1000 ms.
module gated_frequency_meter_unit import gfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    gfm_in_if.sink               sample,
    gfm_out_if.source            result
);

    gfm_entry_t push_entry;
    logic       push_valid;
    logic       push_ready;
    gfm_entry_t pop_entry;
    logic       pop_valid;
    logic       pop_ready;

    gfm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (sample),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    gfm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    gfm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (pop_entry),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule
